>>> sv/dasd_pkg.sv
// Shared types, constants and the month length function for the date offset block.
`default_nettype none

package dasd_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned COUNT_W = 16;

   localparam logic [YEAR_W-1:0]  YEAR_FIRST  = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_LAST   = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_DEC_LEN = 5'd31;

   // floor(y / 100) equals (y * CENT_RECIP) >> CENT_SHIFT for every 14-bit year.
   localparam logic [12:0] CENT_RECIP = 13'd5243;
   localparam int unsigned CENT_SHIFT = 19;
   localparam logic [6:0]  CENT_LEN   = 7'd100;
   localparam logic [6:0]  CENT_TOP   = 7'd99;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SPLIT = 6'b000010,
      ST_RESID = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_STEP  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   // Length of a month; months outside January to December give zero.
   function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

>>> sv/date_add_subtract_days.sv
// Gregorian date plus or minus a day count, walked one month per cycle by a shared subtractor.
// A request passes the year split, the residue and the range check, then walks month by month
// to the result, which waits in the working registers until the receiving side lifts rsp_stall.
// One transaction at a time; the month walk through the single subtractor sets the pace.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
`default_nettype none

module date_add_subtract_days
   import dasd_pkg::*;
#(
   parameter int unsigned COUNT_MAX = 65535
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_func,
   input  wire logic [YEAR_W-1:0]  req_start_year,
   input  wire logic [MONTH_W-1:0] req_start_month,
   input  wire logic [DAY_W-1:0]   req_start_day,
   input  wire logic [COUNT_W-1:0] req_day_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [YEAR_W-1:0]       rsp_result_year,
   output logic [MONTH_W-1:0]      rsp_result_month,
   output logic [DAY_W-1:0]        rsp_result_day,
   output logic                    rsp_range_error
);

   // The day count port is 16 bits wide, so a limit above its full scale never clips.
   localparam int unsigned COUNT_FULL = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      COUNT_W'((COUNT_MAX > COUNT_FULL) ? COUNT_FULL : COUNT_MAX);

   state_type state_ff, state_in;

   logic               func_ff;
   logic [YEAR_W-1:0]  start_year_ff;
   logic [MONTH_W-1:0] start_month_ff;
   logic [DAY_W-1:0]   start_day_ff;

   // Working date, remaining count and the year split into century and year-in-century.
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         quot_ff, quot_in;
   logic [6:0]         yr100_ff, yr100_in;
   logic [1:0]         cent_ff, cent_in;
   logic               err_ff, err_in;

   logic                    leap;
   logic [DAY_W-1:0]        cur_len;
   logic [DAY_W-1:0]        gap;
   logic [DAY_W:0]          sub_b;
   logic [COUNT_W:0]        diff;
   logic                    borrow;
   logic [YEAR_W+12:0]      recip_prod;
   logic [14:0]             cent_prod;

   // The Gregorian rule: a century year is leap only when its century divides by four.
   // Since 100 divides by 4, the low bits of the year-in-century match those of the year.
   assign leap    = (yr100_ff == 7'd0) ? (cent_ff == 2'd0) : (yr100_ff[1:0] == 2'd0);
   assign cur_len = month_len(leap, month_ff);
   assign gap     = cur_len - day_ff;

   // The shared unit: one compare-and-subtract on the remaining count. Going forward it
   // asks whether the count reaches past the end of the month; going back, past day one.
   assign sub_b  = func_ff ? {1'b0, day_ff} : ({1'b0, gap} + 6'd1);
   assign diff   = {1'b0, count_ff} - {{(COUNT_W - DAY_W){1'b0}}, sub_b};
   assign borrow = diff[COUNT_W];

   assign recip_prod = year_ff * CENT_RECIP;
   assign cent_prod  = quot_ff * CENT_LEN;

   always_comb begin
      state_in = state_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      yr100_in = yr100_ff;
      cent_in  = cent_ff;
      err_in   = err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               year_in  = req_start_year;
               month_in = req_start_month;
               day_in   = req_start_day;
               count_in = (req_day_count > COUNT_LIMIT) ? COUNT_LIMIT : req_day_count;
               err_in   = 1'b0;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            quot_in  = recip_prod[YEAR_W+12:CENT_SHIFT];
            state_in = ST_RESID;
         end
         ST_RESID: begin
            yr100_in = 7'(year_ff - cent_prod[YEAR_W-1:0]);
            cent_in  = quot_ff[1:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // A zero month length also catches a month outside January to December.
            if (year_ff < YEAR_FIRST || year_ff > YEAR_LAST ||
                day_ff < DAY_FIRST || day_ff > cur_len) begin
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (borrow) begin
               // The rest of the count lands inside the current month.
               day_in   = func_ff ? (day_ff - count_ff[DAY_W-1:0])
                                  : (day_ff + count_ff[DAY_W-1:0]);
               state_in = ST_DONE;
            end else if (!func_ff) begin
               count_in = diff[COUNT_W-1:0];
               day_in   = DAY_FIRST;
               if (month_ff == MONTH_DEC) begin
                  month_in = MONTH_JAN;
                  if (year_ff == YEAR_LAST) begin
                     err_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     year_in = year_ff + 14'd1;
                     if (yr100_ff == CENT_TOP) begin
                        yr100_in = 7'd0;
                        cent_in  = cent_ff + 2'd1;
                     end else begin
                        yr100_in = yr100_ff + 7'd1;
                     end
                  end
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               // Going back lands on the last day of the month before. Within one year
               // the leap flag does not change, so the length comes from the current one.
               count_in = diff[COUNT_W-1:0];
               if (month_ff == MONTH_JAN) begin
                  month_in = MONTH_DEC;
                  day_in   = DAY_DEC_LEN;
                  if (year_ff == YEAR_FIRST) begin
                     err_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     year_in = year_ff - 14'd1;
                     if (yr100_ff == 7'd0) begin
                        yr100_in = CENT_TOP;
                        cent_in  = cent_ff - 2'd1;
                     end else begin
                        yr100_in = yr100_ff - 7'd1;
                     end
                  end
               end else begin
                  month_in = month_ff - 4'd1;
                  day_in   = month_len(leap, month_ff - 4'd1);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The start date is kept so that an error can hand it back untouched.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         func_ff        <= req_func;
         start_year_ff  <= req_start_year;
         start_month_ff <= req_start_month;
         start_day_ff   <= req_start_day;
      end
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      count_ff <= count_in;
      quot_ff  <= quot_in;
      yr100_ff <= yr100_in;
      cent_ff  <= cent_in;
      err_ff   <= err_in;
   end

   // Only the idle state takes a new transaction; the finished result is held in the
   // working registers until the receiving side lifts rsp_stall.
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_result_year  = err_ff ? start_year_ff  : year_ff;
   assign rsp_result_month = err_ff ? start_month_ff : month_ff;
   assign rsp_result_day   = err_ff ? start_day_ff   : day_ff;
   assign rsp_range_error  = err_ff;

endmodule

`default_nettype wire
